// ----- rtl/srr_pkg.sv -----
package srr_pkg;

	// packet kind codes on the input
	localparam logic [1:0] FUNC_DATA = 2'd0;
	localparam logic [1:0] FUNC_TERM = 2'd1;

	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_NACK    = 2'd1,
		KIND_DELIVER = 2'd2,
		KIND_ERROR   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_DATA = 2'd0,
		OP_TERM = 2'd1,
		OP_BAD  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECIDE = 2'd1,
		ST_DRAIN  = 2'd2
	} state_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] packet_number;
		logic [15:0] payload_bytes;
		logic [15:0] payload_handle;
	} in_item_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [31:0] ack_number;
		logic [15:0] window_report;
		logic [15:0] deliver_handle;
		logic [15:0] deliver_bytes;
		logic [47:0] total_bytes;
		logic        transfer_done;
		logic        last;
	} out_item_t;

	// classified item as it waits between front and back
	typedef struct packed {
		op_t         op;
		logic [31:0] packet_number;
		logic [15:0] payload_bytes;
		logic [15:0] payload_handle;
	} queue_item_t;

endpackage

// ----- rtl/srr_front.sv -----
module srr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srr_pkg::in_item_t    in_item,
	output logic                 q_valid,
	output srr_pkg::queue_item_t q_item,
	input  logic                 q_pop
);
	import srr_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	queue_item_t         entry_q [QDEPTH];
	queue_item_t         classified;
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [PW:0]         count_q;
	logic                push;

	// decode packet kind
	always_comb begin
		classified.packet_number  = in_item.packet_number;
		classified.payload_bytes  = in_item.payload_bytes;
		classified.payload_handle = in_item.payload_handle;
		unique case (in_item.func)
			FUNC_DATA: classified.op = OP_DATA;
			FUNC_TERM: classified.op = OP_TERM;
			default:   classified.op = OP_BAD;
		endcase
	end

	assign in_ready = (count_q != (PW+1)'(QDEPTH));
	assign push     = in_valid & in_ready;
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/srr_back.sv -----
module srr_back #(
	parameter int WINDOW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	input  logic                 q_valid,
	input  srr_pkg::queue_item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srr_pkg::out_item_t   out_item
);
	import srr_pkg::*;

	localparam int IDXW = $clog2(WINDOW);

	state_t            state_q, state_d;
	queue_item_t       cur_q;
	logic [31:0]       next_exp_q;
	logic [IDXW-1:0]   head_q;
	logic [WINDOW-1:0] valid_q;
	logic [47:0]       total_q;
	logic              finished_q;
	logic [15:0]       win_q;

	logic [15:0]       len_mem [WINDOW];
	logic [15:0]       hdl_mem [WINDOW];
	logic [15:0]       rd_len_q;
	logic [15:0]       rd_hdl_q;

	out_item_t         out_q;
	logic              out_valid_q;

	logic              out_free, emit, go, finish, load_cur, wr_en, deliver, set_fin;
	out_item_t         res;
	logic [31:0]       diff;
	logic [IDXW:0]     slot_sum;
	logic [IDXW-1:0]   slot_idx;
	logic [IDXW-1:0]   head_inc;
	logic [IDXW-1:0]   rd_addr;
	logic [48:0]       sum_wide;
	logic [47:0]       total_sat;

	assign out_free = !out_valid_q || out_ready;
	assign go       = !emit || out_free;

	always_comb begin
		diff      = cur_q.packet_number - next_exp_q;
		slot_sum  = {1'b0, head_q} + (IDXW+1)'(diff[IDXW-1:0]);
		slot_idx  = (slot_sum >= (IDXW+1)'(WINDOW)) ?
			IDXW'(slot_sum - (IDXW+1)'(WINDOW)) : slot_sum[IDXW-1:0];
		head_inc  = (head_q == IDXW'(WINDOW-1)) ? '0 : head_q + 1'b1;
		sum_wide  = {1'b0, total_q} + 49'(rd_len_q);
		total_sat = sum_wide[48] ? '1 : sum_wide[47:0];
	end

	always_comb begin
		state_d  = state_q;
		emit     = 1'b0;
		finish   = 1'b0;
		load_cur = 1'b0;
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		deliver  = 1'b0;
		set_fin  = 1'b0;

		res               = '0;
		res.result_kind   = KIND_ACK;
		res.ack_number    = next_exp_q;
		res.window_report = win_q;
		res.total_bytes   = total_q;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop    = 1'b1;
					load_cur = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (finished_q || cur_q.op == OP_BAD) begin
					emit            = 1'b1;
					res.result_kind = KIND_ERROR;
					res.last        = 1'b1;
					finish          = go;
				end else if (cur_q.op == OP_TERM) begin
					emit              = 1'b1;
					res.transfer_done = 1'b1;
					res.last          = 1'b1;
					set_fin           = go;
					finish            = go;
				end else if (cur_q.packet_number < next_exp_q) begin
					// duplicate
					emit     = 1'b1;
					res.last = 1'b1;
					finish   = go;
				end else if (diff >= 32'(WINDOW)) begin
					emit            = 1'b1;
					res.result_kind = KIND_ERROR;
					res.last        = 1'b1;
					finish          = go;
				end else begin
					// in window: store unless already held, nack if ahead
					emit            = (diff != '0);
					res.result_kind = KIND_NACK;
					if (go) begin
						wr_en   = !valid_q[slot_idx];
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				emit = 1'b1;
				if (valid_q[head_q]) begin
					res.result_kind    = KIND_DELIVER;
					res.ack_number     = '0;
					res.window_report  = '0;
					res.deliver_handle = rd_hdl_q;
					res.deliver_bytes  = rd_len_q;
					res.total_bytes    = total_sat;
					deliver            = go;
				end else begin
					res.last = 1'b1;
					finish   = go;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// chain straight into the next queued item
		if (finish) begin
			if (q_valid) begin
				q_pop    = 1'b1;
				load_cur = 1'b1;
				state_d  = ST_DECIDE;
			end else begin
				state_d = ST_IDLE;
			end
		end
	end

	// read address tracks the head after this cycle's update
	assign rd_addr = deliver ? head_inc : head_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			len_mem[slot_idx] <= cur_q.payload_bytes;
			hdl_mem[slot_idx] <= cur_q.payload_handle;
		end
		if (wr_en && slot_idx == rd_addr) begin
			rd_len_q <= cur_q.payload_bytes;
			rd_hdl_q <= cur_q.payload_handle;
		end else begin
			rd_len_q <= len_mem[rd_addr];
			rd_hdl_q <= hdl_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_cur) begin
			cur_q <= q_item;
		end
		if (emit && go) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			next_exp_q  <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			total_q     <= '0;
			finished_q  <= 1'b0;
			win_q       <= 16'd32;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				win_q <= cfg_wr_data;
			end
			if (set_fin) begin
				finished_q <= 1'b1;
			end
			if (wr_en) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (deliver) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_inc;
				next_exp_q      <= next_exp_q + 1'b1;
				total_q         <= total_sat;
			end
			if (emit && go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ----- rtl/selective_repeat_reorder_receiver.sv -----
// Selective-repeat receiver that puts packet descriptors back in order. Each
// input item is one packet: data (id, length, payload handle), terminate, or
// another kind. Data ids inside the window of WINDOW ids from the next expected
// id are held in a ring; a gap gives a NACK, the run of held packets at the head
// then comes out as in-order deliveries with a saturating 48-bit byte count, and
// an ACK closes the item. Duplicates get an ACK; ids past the window, unknown
// kinds and anything after terminate get one error result. The advertised
// window (win_q, reset 32) is copied into every ACK, NACK and error; write it
// only while idle. Timing: a two-entry queue takes new items while the back
// end works. The back end decides on an item in ST_DECIDE (window check, slot
// store, and the NACK or the single result it gives) and then, for data inside
// the window, gives each delivery and the closing ACK in ST_DRAIN. An item that
// yields a single result chains straight into the next item when one already
// waits in the queue; from idle the back end first pops it in ST_IDLE. A result
// that waits on out_ready holds the back end where it is. Slot presence bits
// clear at reset, so the block takes items as soon as reset is released.
module selective_repeat_reorder_receiver #(
	parameter int WINDOW = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  srr_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output srr_pkg::out_item_t out_item,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);
	import srr_pkg::*;

	logic        q_valid;
	logic        q_pop;
	queue_item_t q_item;

	// front: decode packet kind and buffer items
	srr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// back: window check, slot store, drain sequencer, output register
	srr_back #(
		.WINDOW (WINDOW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import srr_pkg::*;

	localparam int WIN = 32;
	localparam int LIMIT = 500000;
	localparam int LONG_HOLD = 400;
	localparam int GAP_MAX = 17;
	localparam logic [15:0] WINDOW_RESET = 16'd32;
	localparam logic [47:0] TOTAL_MAX = '1;
	// packet kinds the block does not handle
	localparam logic [1:0] FUNC_OTHER = 2'd2;
	localparam logic [1:0] FUNC_RSVD = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	selective_repeat_reorder_receiver #(
		.WINDOW(WIN)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// packets waiting to go out, responses waiting to come back
	in_item_t pkt_q[$];
	out_item_t resp_q[$];

	// receiver state as predicted
	logic [31:0] m_next_id = '0;
	bit m_slot_full [WIN];
	logic [15:0] m_slot_len [WIN];
	logic [15:0] m_slot_hdl [WIN];
	int m_head = 0;
	logic [47:0] m_bytes = '0;
	bit m_done = 1'b0;
	logic [15:0] m_window = WINDOW_RESET;

	int err_cnt = 0;
	int cyc = 0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	int send_wait = 0;
	int send_gap_max = GAP_MAX;
	int recv_wait = 0;
	int recv_gap_max = GAP_MAX;
	int hold_req = 0;
	int hold_seen = 0;
	logic [31:0] gen_next = '0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int draw_gap(input int hi);
		if (hi == 0 || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, hi);
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom);
	endfunction

	function automatic in_item_t mk_pkt(input logic [1:0] func, input logic [31:0] id,
		input logic [15:0] len, input logic [15:0] hdl);
		in_item_t p;
		p.func = func;
		p.packet_number = id;
		p.payload_bytes = len;
		p.payload_handle = hdl;
		return p;
	endfunction

	function automatic out_item_t mk_resp(input kind_t k, input logic [31:0] ack,
		input logic [15:0] win, input logic [15:0] hdl, input logic [15:0] len,
		input logic done);
		out_item_t r;
		r.result_kind = k;
		r.ack_number = ack;
		r.window_report = win;
		r.deliver_handle = hdl;
		r.deliver_bytes = len;
		r.total_bytes = m_bytes;
		r.transfer_done = done;
		r.last = 1'b0;
		return r;
	endfunction

	// Work out every response one packet causes and queue them in order.
	task automatic predict_resp(input in_item_t it);
		out_item_t res[$];
		out_item_t r;
		logic [31:0] diff;
		logic [48:0] sum;
		int s;
		int i;
		if (m_done || (it.func != FUNC_DATA && it.func != FUNC_TERM)) begin
			res.push_back(mk_resp(KIND_ERROR, m_next_id, m_window, '0, '0, 1'b0));
		end else if (it.func == FUNC_TERM) begin
			res.push_back(mk_resp(KIND_ACK, m_next_id, m_window, '0, '0, 1'b1));
			m_done = 1'b1;
		end else if (it.packet_number < m_next_id) begin
			// duplicate of something already delivered
			res.push_back(mk_resp(KIND_ACK, m_next_id, m_window, '0, '0, 1'b0));
		end else begin
			diff = it.packet_number - m_next_id;
			if (diff >= WIN) begin
				res.push_back(mk_resp(KIND_ERROR, m_next_id, m_window, '0, '0, 1'b0));
			end else begin
				s = m_head + int'(diff);
				if (s >= WIN)
					s -= WIN;
				// a repeat of a held id keeps the first length and handle
				if (!m_slot_full[s]) begin
					m_slot_full[s] = 1'b1;
					m_slot_len[s] = it.payload_bytes;
					m_slot_hdl[s] = it.payload_handle;
				end
				if (diff != 0)
					res.push_back(mk_resp(KIND_NACK, m_next_id, m_window, '0, '0, 1'b0));
				for (i = 0; i < WIN && m_slot_full[m_head]; i++) begin
					sum = {1'b0, m_bytes} + 49'(m_slot_len[m_head]);
					if (sum[48])
						m_bytes = TOTAL_MAX;
					else
						m_bytes = sum[47:0];
					res.push_back(mk_resp(KIND_DELIVER, '0, '0, m_slot_hdl[m_head],
						m_slot_len[m_head], 1'b0));
					m_slot_full[m_head] = 1'b0;
					m_head = (m_head == WIN - 1) ? 0 : m_head + 1;
					m_next_id = m_next_id + 1;
				end
				res.push_back(mk_resp(KIND_ACK, m_next_id, m_window, '0, '0, 1'b0));
			end
		end
		r = res.pop_back();
		r.last = 1'b1;
		res.push_back(r);
		foreach (res[j])
			resp_q.push_back(res[j]);
	endtask

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cyc, what);
		err_cnt++;
	endtask

	task automatic chk_field(input string name, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Sampling side: predict on each accepted packet, then check each response.
	always @(posedge clk) begin : mon
		out_item_t want;
		cyc++;
		in_fire <= arst_n && in_valid && in_ready;
		out_fire <= arst_n && out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			predict_resp(in_item);
		if (arst_n && out_valid && out_ready) begin
			if (resp_q.size() == 0) begin
				report($sformatf("response with nothing expected, kind %0d",
					out_item.result_kind));
			end else begin
				want = resp_q.pop_front();
				chk_field("result_kind", 64'(out_item.result_kind),
					64'(want.result_kind));
				chk_field("ack_number", 64'(out_item.ack_number), 64'(want.ack_number));
				chk_field("window_report", 64'(out_item.window_report),
					64'(want.window_report));
				chk_field("deliver_handle", 64'(out_item.deliver_handle),
					64'(want.deliver_handle));
				chk_field("deliver_bytes", 64'(out_item.deliver_bytes),
					64'(want.deliver_bytes));
				chk_field("total_bytes", 64'(out_item.total_bytes),
					64'(want.total_bytes));
				chk_field("transfer_done", 64'(out_item.transfer_done),
					64'(want.transfer_done));
				chk_field("last", 64'(out_item.last), 64'(want.last));
			end
		end
		if (cyc > LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("status: fail");
			$finish;
		end
	end

	// Sender: holds each packet until taken, then idles for its drawn gap.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_fire)) begin
			if (send_wait != 0) begin
				send_wait <= send_wait - 1;
				in_valid <= 1'b0;
			end else if (pkt_q.size() != 0) begin
				in_item <= pkt_q.pop_front();
				in_valid <= 1'b1;
				send_wait <= draw_gap(send_gap_max);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a gap after each response, plus the long hold when asked.
	always @(negedge clk) begin : rx
		int w;
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				recv_wait <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1);
			end else if (out_fire) begin
				w = draw_gap(recv_gap_max);
				recv_wait <= w;
				out_ready <= (w == 0);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic wait_drained();
		@(posedge clk);
		#1;
		while (pkt_q.size() != 0 || in_valid || resp_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (4) @(posedge clk);
		#1;
	endtask

	task automatic set_window(input logic [15:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		m_window = v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	// Runs of consecutive ids in order, reversed or shuffled, so that every one
	// eventually drains, with noise mixed in.
	task automatic gen_traffic(input int n_items);
		logic [31:0] ids[$];
		logic [31:0] t;
		int cnt;
		int k;
		int order;
		int j;
		int m;
		cnt = 0;
		while (cnt < n_items) begin
			k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, WIN) : $urandom_range(1, 8);
			order = $urandom_range(0, 3);
			ids.delete();
			for (j = 0; j < k; j++)
				ids.push_back((order == 0) ? gen_next + k - 1 - j : gen_next + j);
			if (order >= 2) begin
				for (j = k - 1; j > 0; j--) begin
					m = $urandom_range(0, j);
					t = ids[j];
					ids[j] = ids[m];
					ids[m] = t;
				end
			end
			for (j = 0; j < k; j++) begin
				if ($urandom_range(0, 4) == 0) begin
					case ($urandom_range(0, 4))
						0: begin
							if (gen_next != 0)
								pkt_q.push_back(mk_pkt(FUNC_DATA, $urandom_range(0, gen_next - 1),
									rnd16(), rnd16()));
							else
								pkt_q.push_back(mk_pkt(FUNC_OTHER, $urandom, rnd16(), rnd16()));
						end
						1: begin
							pkt_q.push_back(mk_pkt(FUNC_DATA,
								gen_next + k + 2 * WIN + $urandom_range(0, 4095),
								rnd16(), rnd16()));
						end
						2: begin
							pkt_q.push_back(mk_pkt($urandom_range(0, 1) ? FUNC_OTHER : FUNC_RSVD,
								$urandom, rnd16(), rnd16()));
						end
						3: begin
							if (j != 0)
								pkt_q.push_back(mk_pkt(FUNC_DATA, ids[$urandom_range(0, j - 1)],
									rnd16(), rnd16()));
							else
								pkt_q.push_back(mk_pkt(FUNC_DATA, $urandom, rnd16(), rnd16()));
						end
						default: begin
							pkt_q.push_back(mk_pkt(FUNC_DATA, $urandom, rnd16(), rnd16()));
						end
					endcase
					cnt++;
				end
				pkt_q.push_back(mk_pkt(FUNC_DATA, ids[j], rnd16(), rnd16()));
				cnt++;
			end
			gen_next = gen_next + k;
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed, window at its reset value
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd0, 16'h0000, 16'h0000));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd0, 16'hFFFF, 16'hFFFF));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd2, 16'hFFFF, 16'hFFFF));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd2, 16'h0001, 16'h0001));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd1, 16'h8000, 16'h5555));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd3 + WIN - 1, 16'h1234, 16'hAAAA));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd3 + WIN, 16'h4321, 16'h0F0F));
		pkt_q.push_back(mk_pkt(FUNC_OTHER, 32'd3, 16'h0010, 16'h0020));
		pkt_q.push_back(mk_pkt(FUNC_RSVD, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'h8000_0000, 16'h0000, 16'h0000));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd3, 16'h00FF, 16'hFF00));
		gen_next = 32'd4;
		wait_drained();

		// window of one
		set_window(16'd1);
		gen_traffic(30);
		wait_drained();

		// largest window; receiver stalls long while the sender keeps pushing
		set_window(16'hFFFF);
		send_gap_max = 0;
		hold_req++;
		gen_traffic(20);
		wait_drained();
		send_gap_max = GAP_MAX;
		gen_traffic(12);
		wait_drained();

		// zero window, back to back on both sides
		set_window(16'd0);
		send_gap_max = 0;
		recv_gap_max = 0;
		gen_traffic(30);
		wait_drained();

		send_gap_max = GAP_MAX;
		recv_gap_max = GAP_MAX;
		set_window(16'($urandom_range(1, 65535)));
		gen_traffic(30);
		wait_drained();

		// terminate, then everything after it must be refused
		set_window(16'($urandom_range(1, 65535)));
		pkt_q.push_back(mk_pkt(FUNC_DATA, gen_next + 1, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_TERM, $urandom, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_DATA, gen_next, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_OTHER, $urandom, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_RSVD, $urandom, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_TERM, $urandom, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_DATA, 32'd0, rnd16(), rnd16()));
		pkt_q.push_back(mk_pkt(FUNC_DATA, $urandom, rnd16(), rnd16()));
		wait_drained();

		repeat (40) @(posedge clk);
		#1;
		if (resp_q.size() != 0)
			report($sformatf("%0d responses never arrived", resp_q.size()));
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
